FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the design files.
// Each macro expects clk and rst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold at any edge where the antecedent holds.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/trkacc_pkg.sv
// ----------------------------------------------------------------------------
// trkacc_pkg
// Shared types, constants and helper functions for the trackball motion
// accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package trkacc_pkg;

    localparam int ACC_W      = 16;
    localparam int DELTA_W    = 9;
    localparam int PROD_W     = 30;
    localparam int SAT_W      = PROD_W + 1;
    localparam int GAIN_W     = 4;
    localparam int DEB_W      = 8;
    localparam int TIME_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int REP_W      = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int CLICK_BIT  = 7;
    localparam int DRAIN_LIMIT = 127;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [GAIN_W-1:0] GAIN_RESET     = GAIN_W'(3);
    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = DEB_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_GAIN  = 8'd0,
        REG_DEBOUNCE_MS = 8'd1
    } cfg_reg_t;

    // One classified poll handed from the front to the back
    typedef struct packed {
        logic                      motion;   // read ok and switch released
        logic                      press;    // read ok and switch pressed
        logic                      scroll;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic                      click;
        logic [TIME_W-1:0]         now;
        logic                      other_nz; // buttons or horizontal wheel nonzero
    } trkacc_op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } trkacc_q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CUBE,
        BK_GAIN,
        BK_APPLY
    } trkacc_bk_state_t;

    typedef struct packed {
        logic signed [REP_W-1:0] rep;
        logic signed [ACC_W-1:0] rem;
    } trkacc_drain_t;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SAT_W-1:0] v);
        localparam logic signed [SAT_W-1:0] MAX_S = SAT_W'(2 ** (ACC_W - 1) - 1);
        localparam logic signed [SAT_W-1:0] MIN_S = -MAX_S - SAT_W'(1);
        logic signed [ACC_W-1:0] r;
        if (v > MAX_S)
            r = ACC_W'(MAX_S);
        else if (v < MIN_S)
            r = ACC_W'(MIN_S);
        else
            r = ACC_W'(v);
        return r;
    endfunction

    function automatic trkacc_drain_t drain_acc(input logic signed [ACC_W-1:0] a);
        localparam logic signed [ACC_W-1:0] LIM = ACC_W'(DRAIN_LIMIT);
        trkacc_drain_t d;
        if (a > LIM)
        begin
            d.rep = REP_W'(LIM);
            d.rem = a - LIM;
        end
        else if (a < -LIM)
        begin
            d.rep = REP_W'(-LIM);
            d.rem = a + LIM;
        end
        else
        begin
            d.rep = REP_W'(a);
            d.rem = '0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: design/trkacc_if.sv
// ----------------------------------------------------------------------------
// trkacc interfaces
// Poll, report and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface trkacc_poll_if;
    import trkacc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     read_ok;
    logic [BYTE_W-1:0]        count_up;
    logic [BYTE_W-1:0]        count_down;
    logic [BYTE_W-1:0]        count_left;
    logic [BYTE_W-1:0]        count_right;
    logic [BYTE_W-1:0]        switch_byte;
    logic                     scroll_mode;
    logic [TIME_W-1:0]        now_ms;
    logic [BYTE_W-1:0]        buttons_in;
    logic signed [BYTE_W-1:0] wheel_h_in;

    modport source (output valid, read_ok, count_up, count_down, count_left, count_right,
                    switch_byte, scroll_mode, now_ms, buttons_in, wheel_h_in,
                    input ready);
    modport sink   (input valid, read_ok, count_up, count_down, count_left, count_right,
                    switch_byte, scroll_mode, now_ms, buttons_in, wheel_h_in,
                    output ready);
endinterface

interface trkacc_report_if;
    import trkacc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [REP_W-1:0] report_x;
    logic signed [REP_W-1:0] report_y;
    logic signed [REP_W-1:0] report_v;
    logic                    toggle_layer;
    logic                    send_report;

    modport source (output valid, report_x, report_y, report_v, toggle_layer, send_report,
                    input ready);
    modport sink   (input valid, report_x, report_y, report_v, toggle_layer, send_report,
                    output ready);
endinterface

interface trkacc_cfg_if;
    import trkacc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/trackball_motion_accumulator_unit.sv
// ----------------------------------------------------------------------------
// trackball_motion_accumulator_unit
// Trackball motion accumulator. Each poll request on the poll channel yields
// exactly one report request on the report channel, in order. A poll that
// moves the pointer passes through the execution unit in steps (queue pop with
// the square, cube, gain, then accumulate and drain), using the two-lane
// multiplier that is reused for the three products; every other poll goes from
// the queue pop straight to accumulate and drain. A short queue lets polls be
// taken while the execution unit or the report register is busy. Products and
// accumulators saturate to 16 bits. Configuration writes (accel_gain at index 0,
// debounce_ms at index 1) are always taken; other indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module trackball_motion_accumulator_unit #(
    parameter int QUEUE_DEPTH = trkacc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    trkacc_poll_if.sink       poll,
    trkacc_report_if.source   report,
    trkacc_cfg_if.sink        cfg
);
    import trkacc_pkg::*;

    logic [GAIN_W-1:0] accel_gain_reg, accel_gain_next;
    logic [DEB_W-1:0]  debounce_ms_reg, debounce_ms_next;

    logic             q_push, q_pop;
    trkacc_op_t       q_data, q_head;
    trkacc_q_status_t q_stat;
    logic             rep_in_range;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        accel_gain_next  = accel_gain_reg;
        debounce_ms_next = debounce_ms_reg;
        if (cfg.valid)
        begin
            if (cfg.index == REG_ACCEL_GAIN)
                accel_gain_next = cfg.data[GAIN_W-1:0];
            else if (cfg.index == REG_DEBOUNCE_MS)
                debounce_ms_next = cfg.data[DEB_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_gain_reg  <= GAIN_RESET;
            debounce_ms_reg <= DEBOUNCE_RESET;
        end
        else
        begin
            accel_gain_reg  <= accel_gain_next;
            debounce_ms_reg <= debounce_ms_next;
        end
    end

    trkacc_front u_front (
        .poll   (poll),
        .q_full (q_stat.full),
        .q_push (q_push),
        .q_data (q_data)
    );

    trkacc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_stat)
    );

    trkacc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .accel_gain  (accel_gain_reg),
        .debounce_ms (debounce_ms_reg),
        .q_status    (q_stat),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .report      (report)
    );

    // drained fields never reach the minimum of int8
    assign rep_in_range = (report.report_x != 8'h80) && (report.report_y != 8'h80)
                          && (report.report_v != 8'h80);

    // queue must never be written when full nor read when empty
    `ASSERT_IMPLIES(a_no_push_full, q_push, !q_stat.full, "poll queued while queue full")
    `ASSERT_IMPLIES(a_no_pop_empty, q_pop, !q_stat.empty, "queue popped while empty")
    `ASSERT_IMPLIES(a_report_range, report.valid, rep_in_range, "report field out of range")
    `ASSERT_ALWAYS(a_status_sane, !(q_stat.full && q_stat.empty), "queue both full and empty")

endmodule

`default_nettype wire

FILE: design/trkacc_front.sv
// ----------------------------------------------------------------------------
// trkacc_front
// Takes poll requests, masks failed reads, forms the signed deltas and
// classifies the poll before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module trkacc_front (
    trkacc_poll_if.sink            poll,
    input  wire logic              q_full,
    output logic                   q_push,
    output trkacc_pkg::trkacc_op_t q_data
);
    import trkacc_pkg::*;

    logic [BYTE_W-1:0] sw;

    assign poll.ready = !q_full;
    assign q_push     = poll.valid && !q_full;

    // a failed read counts the switch byte as zero
    assign sw = poll.read_ok ? poll.switch_byte : '0;

    always_comb
    begin
        q_data.motion   = poll.read_ok && (sw == '0);
        q_data.press    = poll.read_ok && (sw != '0);
        q_data.scroll   = poll.scroll_mode;
        q_data.dy       = $signed({1'b0, poll.count_down}) - $signed({1'b0, poll.count_up});
        q_data.dx       = $signed({1'b0, poll.count_left}) - $signed({1'b0, poll.count_right});
        q_data.click    = sw[CLICK_BIT];
        q_data.now      = poll.now_ms;
        q_data.other_nz = (poll.buttons_in != '0) || (poll.wheel_h_in != '0);
    end

endmodule

`default_nettype wire

FILE: design/trkacc_queue.sv
// ----------------------------------------------------------------------------
// trkacc_queue
// Short first-in first-out queue of classified polls between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module trkacc_queue #(
    parameter int DEPTH = trkacc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire trkacc_pkg::trkacc_op_t     push_data,
    input  wire logic                       pop,
    output trkacc_pkg::trkacc_op_t          head,
    output trkacc_pkg::trkacc_q_status_t    status
);
    import trkacc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    trkacc_op_t        entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

FILE: design/trkacc_back.sv
// ----------------------------------------------------------------------------
// trkacc_back
// Executes one classified poll at a time: gained cube of the deltas on two
// multiplier lanes, saturating accumulation, debounce, drain and report.
// ----------------------------------------------------------------------------
`default_nettype none

module trkacc_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [trkacc_pkg::GAIN_W-1:0]    accel_gain,
    input  wire logic [trkacc_pkg::DEB_W-1:0]     debounce_ms,
    input  wire trkacc_pkg::trkacc_q_status_t     q_status,
    input  wire trkacc_pkg::trkacc_op_t           q_head,
    output logic                                  q_pop,
    trkacc_report_if.source                       report
);
    import trkacc_pkg::*;

    trkacc_bk_state_t state_reg, state_next;
    trkacc_op_t       op_reg, op_next;

    logic signed [PROD_W-1:0]  prod_x_reg, prod_x_next;
    logic signed [PROD_W-1:0]  prod_y_reg, prod_y_next;
    logic signed [PROD_W-1:0]  mul_a_x, mul_a_y;
    logic signed [DELTA_W-1:0] mul_b_x, mul_b_y;

    logic signed [ACC_W-1:0] acc_x_reg, acc_x_next;
    logic signed [ACC_W-1:0] acc_y_reg, acc_y_next;
    logic signed [ACC_W-1:0] acc_w_reg, acc_w_next;
    logic                    deb_active_reg, deb_active_next;
    logic [TIME_W-1:0]       deb_start_reg, deb_start_next;
    logic                    click_prev_reg, click_prev_next;
    logic                    prev_active_reg, prev_active_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [REP_W-1:0] rep_x_reg, rep_y_reg, rep_v_reg;
    logic                    toggle_reg, send_reg;

    logic                    start_ptr;
    logic                    pointer_go, scroll_go, apply_fire;
    logic signed [ACC_W-1:0] acc_x_new, acc_y_new, acc_w_new;
    trkacc_drain_t           drn_x, drn_y, drn_w;
    logic                    deb_mid;
    logic [TIME_W-1:0]       elapsed;
    logic                    active;

    // pointer motion only when the switch is released, scroll mode is off and no window is open
    assign start_ptr  = q_head.motion && !q_head.scroll && !deb_active_reg;
    assign pointer_go = op_reg.motion && !op_reg.scroll && !deb_active_reg;
    assign scroll_go  = op_reg.motion && op_reg.scroll && !deb_active_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (!q_status.empty)
                    state_next = start_ptr ? BK_CUBE : BK_APPLY;
            BK_CUBE:
                state_next = BK_GAIN;
            BK_GAIN:
                state_next = BK_APPLY;
            BK_APPLY:
                if (apply_fire)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // state outputs: pop, multiplier operand selection, result launch
    always_comb
    begin
        q_pop      = 1'b0;
        apply_fire = 1'b0;
        mul_a_x    = prod_x_reg;
        mul_a_y    = prod_y_reg;
        mul_b_x    = op_reg.dx;
        mul_b_y    = op_reg.dy;
        unique case (state_reg)
            BK_IDLE:
            begin
                q_pop   = !q_status.empty;
                mul_a_x = PROD_W'(q_head.dx);
                mul_a_y = PROD_W'(q_head.dy);
                mul_b_x = q_head.dx;
                mul_b_y = q_head.dy;
            end
            BK_CUBE:
            begin
                mul_b_x = op_reg.dx;
                mul_b_y = op_reg.dy;
            end
            BK_GAIN:
            begin
                mul_b_x = $signed(DELTA_W'(accel_gain));
                mul_b_y = $signed(DELTA_W'(accel_gain));
            end
            BK_APPLY:
                apply_fire = !out_valid_reg || report.ready;
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        op_next     = q_pop ? q_head : op_reg;
        prod_x_next = (state_reg == BK_APPLY) ? prod_x_reg : mul_a_x * mul_b_x;
        prod_y_next = (state_reg == BK_APPLY) ? prod_y_reg : mul_a_y * mul_b_y;

        acc_x_new = acc_x_reg;
        acc_y_new = acc_y_reg;
        acc_w_new = acc_w_reg;
        if (pointer_go)
        begin
            acc_x_new = sat_acc(SAT_W'(acc_x_reg) + SAT_W'(sat_acc(SAT_W'(prod_x_reg))));
            acc_y_new = sat_acc(SAT_W'(acc_y_reg) + SAT_W'(sat_acc(SAT_W'(prod_y_reg))));
        end
        if (scroll_go)
            acc_w_new = sat_acc(SAT_W'(acc_w_reg) - SAT_W'(op_reg.dy));

        // a press opens or restarts the window; expiry checked afterwards
        deb_mid        = op_reg.press ? 1'b1 : deb_active_reg;
        deb_start_next = op_reg.press ? op_reg.now : deb_start_reg;
        elapsed        = op_reg.now - deb_start_next;
        if (elapsed > TIME_W'(debounce_ms))
            deb_mid = 1'b0;

        drn_x  = drain_acc(acc_x_new);
        drn_y  = drain_acc(acc_y_new);
        drn_w  = drain_acc(acc_w_new);
        active = op_reg.other_nz || (drn_x.rep != '0) || (drn_y.rep != '0)
                 || (drn_w.rep != '0);

        if (!apply_fire)
            deb_start_next = deb_start_reg;
        acc_x_next       = apply_fire ? drn_x.rem : acc_x_reg;
        acc_y_next       = apply_fire ? drn_y.rem : acc_y_reg;
        acc_w_next       = apply_fire ? drn_w.rem : acc_w_reg;
        deb_active_next  = apply_fire ? deb_mid : deb_active_reg;
        click_prev_next  = apply_fire ? op_reg.click : click_prev_reg;
        prev_active_next = apply_fire ? active : prev_active_reg;

        if (apply_fire)
            out_valid_next = 1'b1;
        else if (report.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            acc_x_reg       <= '0;
            acc_y_reg       <= '0;
            acc_w_reg       <= '0;
            deb_active_reg  <= 1'b0;
            deb_start_reg   <= '0;
            click_prev_reg  <= 1'b0;
            prev_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            acc_x_reg       <= acc_x_next;
            acc_y_reg       <= acc_y_next;
            acc_w_reg       <= acc_w_next;
            deb_active_reg  <= deb_active_next;
            deb_start_reg   <= deb_start_next;
            click_prev_reg  <= click_prev_next;
            prev_active_reg <= prev_active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        if (apply_fire)
        begin
            rep_x_reg  <= drn_x.rep;
            rep_y_reg  <= drn_y.rep;
            rep_v_reg  <= drn_w.rep;
            toggle_reg <= op_reg.click && !click_prev_reg;
            send_reg   <= active || prev_active_reg;
        end
    end

    assign report.valid        = out_valid_reg;
    assign report.report_x     = rep_x_reg;
    assign report.report_y     = rep_y_reg;
    assign report.report_v     = rep_v_reg;
    assign report.toggle_layer = toggle_reg;
    assign report.send_report  = send_reg;

endmodule

`default_nettype wire
